/* design/rfr_pkg.sv */
// ----------------------------------------------------------------------------
// RGBW fade ramp package
// Shared constants, register codes, lane control struct and the fade move.
// ----------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

	localparam int MAX_CHANNELS = 4;

	localparam int LEVEL_W  = 7;
	localparam int VALUE_W  = 8;
	localparam int STEP_W   = 7;
	localparam int TICK_W   = 8;
	localparam int COUNT_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int PROD_W   = LEVEL_W + VALUE_W;

	// divide by 100 as multiply by 5243 and shift by 19; exact for products up to 25500
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd20;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_RESET    = 3'd4;
	localparam logic [STEP_W-1:0]  STEP_RESET     = 7'd1;
	localparam logic [TICK_W-1:0]  INTERVAL_RESET = 8'd10;

	typedef struct packed {
		logic load_s1;  // request accepted, state updates
		logic fade;     // this request carries a fade step
		logic load_s2;
		logic load_s3;
	} lane_ctrl_t;

	// move cur toward tgt by step, landing exactly on tgt
	function automatic logic [VALUE_W-1:0] move_toward(
		input logic [VALUE_W-1:0] cur,
		input logic [VALUE_W-1:0] tgt,
		input logic [STEP_W-1:0]  step
	);
		logic [VALUE_W-1:0] diff;
		logic [VALUE_W-1:0] res;
		res = cur;
		if (cur < tgt) begin
			diff = tgt - cur;
			res = (diff > VALUE_W'(step)) ? cur + VALUE_W'(step) : tgt;
		end else if (cur > tgt) begin
			diff = cur - tgt;
			res = (diff > VALUE_W'(step)) ? cur - VALUE_W'(step) : tgt;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* design/rfr_lane.sv */
// ----------------------------------------------------------------------------
// RGBW fade ramp channel lane
// Holds one channel value, fades it, and computes its PWM duty.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_lane (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  rfr_pkg::lane_ctrl_t       ctrl,
	input  wire                             enable,
	input  wire  [rfr_pkg::STEP_W-1:0]      step_size,
	input  wire  [rfr_pkg::VALUE_W-1:0]     target,
	input  wire  [rfr_pkg::LEVEL_W-1:0]     level,
	output logic                            match,
	output logic [rfr_pkg::VALUE_W-1:0]     duty
);

	logic [rfr_pkg::VALUE_W-1:0] value_q;
	logic [rfr_pkg::VALUE_W-1:0] value_next;
	logic                        enable_s1;
	logic                        match_s1;
	logic [rfr_pkg::PROD_W-1:0]  prod_s2;
	logic [rfr_pkg::VALUE_W-1:0] duty_s3;
	logic [rfr_pkg::PROD_W+rfr_pkg::RECIP_W-1:0] scaled;
	logic [rfr_pkg::PROD_W+rfr_pkg::RECIP_W-rfr_pkg::RECIP_SHIFT-1:0] quot;

	always_comb begin
		value_next = value_q;
		if (ctrl.fade && enable) begin
			value_next = rfr_pkg::move_toward(value_q, target, step_size);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctrl.load_s1) begin
			value_q <= value_next;
		end
	end

	// value_q itself is the stage 1 copy of the channel value
	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			enable_s1 <= enable;
			match_s1  <= !enable || (value_next == target);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			prod_s2 <= enable_s1 ? rfr_pkg::PROD_W'(level) * rfr_pkg::PROD_W'(value_q) : '0;
		end
	end

	assign scaled = (rfr_pkg::PROD_W+rfr_pkg::RECIP_W)'(prod_s2) *
	                (rfr_pkg::PROD_W+rfr_pkg::RECIP_W)'(rfr_pkg::RECIP_100);
	assign quot   = scaled[rfr_pkg::PROD_W+rfr_pkg::RECIP_W-1:rfr_pkg::RECIP_SHIFT];

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			duty_s3 <= (quot > 255) ? '1 : rfr_pkg::VALUE_W'(quot);
		end
	end

	assign match = match_s1;
	assign duty  = duty_s3;

endmodule

`default_nettype wire

/* design/rgbw_led_fade_ramp_core.sv */
// Stages: 1 holds the fade state, 2 the level product, 3 the duty output register.
// Throughput: one request per cycle unless out_stall holds the pipeline; the fade
// state (level, channel values, tick counter) updates in the accept cycle, two
// more stages form the duty. Reset: level 20, channel values and tick counter 0,
// registers at their defaults, pipeline empty.
// ----------------------------------------------------------------------------
// RGBW LED fade ramp core
// Tick-driven dimmer: four channel lanes fade and compute duty, level shared.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbw_led_fade_ramp_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [rfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [rfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [rfr_pkg::LEVEL_W-1:0]        target_level,
	input  wire  [rfr_pkg::VALUE_W-1:0]        target_red,
	input  wire  [rfr_pkg::VALUE_W-1:0]        target_green,
	input  wire  [rfr_pkg::VALUE_W-1:0]        target_blue,
	input  wire  [rfr_pkg::VALUE_W-1:0]        target_white,
	input  wire                                lamp_on,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [rfr_pkg::VALUE_W-1:0]        duty_ch0,
	output logic [rfr_pkg::VALUE_W-1:0]        duty_ch1,
	output logic [rfr_pkg::VALUE_W-1:0]        duty_ch2,
	output logic [rfr_pkg::VALUE_W-1:0]        duty_ch3,
	output logic                               settled
);

	logic [rfr_pkg::COUNT_W-1:0] channel_count_q;
	logic [rfr_pkg::STEP_W-1:0]  step_size_q;
	logic [rfr_pkg::TICK_W-1:0]  step_interval_q;

	logic [rfr_pkg::TICK_W-1:0]  tick_q;
	logic [rfr_pkg::LEVEL_W-1:0] level_q;
	logic [rfr_pkg::LEVEL_W-1:0] level_next;
	logic [rfr_pkg::LEVEL_W-1:0] level_tgt;
	logic                        level_match_s1;
	logic                        settled_s2;
	logic                        settled_s3;

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;
	logic fade;

	rfr_pkg::lane_ctrl_t ctrl;
	logic [rfr_pkg::COUNT_W-1:0]      n_eff;
	logic [rfr_pkg::MAX_CHANNELS-1:0] lane_en;
	logic [rfr_pkg::MAX_CHANNELS-1:0] lane_match;
	logic [rfr_pkg::VALUE_W-1:0]      lane_tgt  [rfr_pkg::MAX_CHANNELS];
	logic [rfr_pkg::VALUE_W-1:0]      lane_duty [rfr_pkg::MAX_CHANNELS];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= rfr_pkg::COUNT_RESET;
			step_size_q     <= rfr_pkg::STEP_RESET;
			step_interval_q <= rfr_pkg::INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rfr_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data[rfr_pkg::COUNT_W-1:0];
				rfr_pkg::REG_STEP_SIZE:     step_size_q     <= cfg_data[rfr_pkg::STEP_W-1:0];
				rfr_pkg::REG_STEP_INTERVAL: step_interval_q <= cfg_data[rfr_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign ready_s3 = !valid_s3 || !out_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	assign fade = (tick_q >= step_interval_q);

	always_comb begin
		ctrl.load_s1 = in_valid && ready_s1;
		ctrl.fade    = fade;
		ctrl.load_s2 = valid_s1 && ready_s2;
		ctrl.load_s3 = valid_s2 && ready_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// enabled lanes: count 0 acts as one, above the lane count as all
	always_comb begin
		n_eff = channel_count_q;
		if (channel_count_q == '0) begin
			n_eff = rfr_pkg::COUNT_W'(1);
		end else if (channel_count_q > rfr_pkg::COUNT_W'(rfr_pkg::MAX_CHANNELS)) begin
			n_eff = rfr_pkg::COUNT_W'(rfr_pkg::MAX_CHANNELS);
		end
		for (int i = 0; i < rfr_pkg::MAX_CHANNELS; i++) begin
			lane_en[i] = (rfr_pkg::COUNT_W'(i) < n_eff);
		end
	end

	// level fade
	always_comb begin
		level_tgt = (target_level > rfr_pkg::LEVEL_MAX) ? rfr_pkg::LEVEL_MAX : target_level;
		if (!lamp_on) begin
			level_tgt = '0;
		end
		level_next = level_q;
		if (fade) begin
			level_next = rfr_pkg::LEVEL_W'(rfr_pkg::move_toward(rfr_pkg::VALUE_W'(level_q),
				rfr_pkg::VALUE_W'(level_tgt), step_size_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			level_q <= rfr_pkg::LEVEL_RESET;
		end else if (ctrl.load_s1) begin
			tick_q  <= fade ? '0 : tick_q + 1'b1;
			level_q <= level_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			level_match_s1 <= (level_next == level_tgt);
		end
	end

	assign lane_tgt[0] = target_red;
	assign lane_tgt[1] = target_green;
	assign lane_tgt[2] = target_blue;
	assign lane_tgt[3] = target_white;

	for (genvar g = 0; g < rfr_pkg::MAX_CHANNELS; g++) begin : g_lane
		rfr_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.enable    (lane_en[g]),
			.step_size (step_size_q),
			.target    (lane_tgt[g]),
			.level     (level_q),
			.match     (lane_match[g]),
			.duty      (lane_duty[g])
		);
	end

	// merge: settled needs the level and every enabled lane on target
	always_ff @(posedge clk) begin
		if (ctrl.load_s2) settled_s2 <= level_match_s1 && (&lane_match);
		if (ctrl.load_s3) settled_s3 <= settled_s2;
	end

	assign out_valid = valid_s3;
	assign duty_ch0  = lane_duty[0];
	assign duty_ch1  = lane_duty[1];
	assign duty_ch2  = lane_duty[2];
	assign duty_ch3  = lane_duty[3];
	assign settled   = settled_s3;

`ifndef SYNTHESIS
	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_s1 && fade |=> tick_q == '0)
		else $error("tick counter not cleared after fade step");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= rfr_pkg::LEVEL_MAX)
		else $error("level above maximum");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_s1 |=> valid_s1)
		else $error("accepted request lost in stage 1");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && out_stall |=> valid_s3)
		else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire
